// ===== rtl/vertex_dedup_indexer_macros.svh =====
// Assertion macros shared by the vertex deduplication indexer RTL.
`ifndef VERTEX_DEDUP_INDEXER_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks that a condition holds at every clock edge out of reset.
`define VDI_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("vertex_dedup_indexer: invariant violated");
// Checks that a trigger is followed by a consequence in the next cycle.
`define VDI_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("vertex_dedup_indexer: sequencing violated");
`else
`define VDI_ASSERT(label, cond)
`define VDI_ASSERT_NEXT(label, trig, cons)
`endif

`endif

// ===== rtl/vdi_pkg.sv =====
// Shared constants, types and state codes of the vertex deduplication indexer.
package vdi_pkg;

  // Table size and derived widths.
  localparam int MaxVertices = 1024;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CntW        = IdxW + 1;

  // Fixed field widths.
  localparam int CoordW  = 32;
  localparam int TolW    = 31;
  localparam int OutIdxW = 10;

  // Tolerance after reset: 0.01 in Q16.16, rounded down.
  localparam logic [TolW-1:0] TolReset = TolW'(655);

  // One vertex as held in a table cell.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vertex_t;

  // One result word.
  typedef struct packed {
    logic [OutIdxW-1:0] index;
    logic               is_new;
    logic               full;
  } result_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

endpackage

// ===== rtl/vertex_dedup_indexer.sv =====
// Top level of the vertex deduplication indexer: cell ring, sequencer and ports.
//
// Usage: one vertex word (start_mesh, pos_x, pos_y, pos_z) enters on the
// in_valid_i/in_ready_o channel; one result word (vertex_index, is_new,
// table_full) leaves on the out_valid_o/out_ready_i channel for each input.
// The unique table is a ring of MaxVertices cells. For each word the ring
// makes one full revolution, one cell per cycle, so entry t sits at the head
// compare in scan step t; the first match wins, otherwise the vertex is
// written into the ring at the first free position, if one is left.
// Sequence: a word is accepted in the idle state, scanned in the scan state
// over one full ring revolution, and finished in the done state, which loads
// the output register. A new word is taken only in the idle state, so the
// block takes no new word before the last one has left the done state.
// The tolerance register is written through cfg_we_i/cfg_wdata_i.
// Reset clears the entry count, the sequencer and the output valid, and sets
// the tolerance to 655; table contents need no clearing.
// When the receiver stalls, the result word waits in the output register and
// a further input word can still be scanned; its result waits in the finish
// state until the output register frees up.
`include "vertex_dedup_indexer_macros.svh"

module vertex_dedup_indexer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration port.
  input  logic                             cfg_we_i,
  input  logic [vdi_pkg::TolW-1:0]         cfg_wdata_i,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             start_mesh_i,
  input  logic signed [vdi_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [vdi_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [vdi_pkg::CoordW-1:0] pos_z_i,
  // Output channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [vdi_pkg::OutIdxW-1:0]      vertex_index_o,
  output logic                             is_new_o,
  output logic                             table_full_o
);

  localparam int MaxV = vdi_pkg::MaxVertices;
  localparam int IdxW = vdi_pkg::IdxW;
  localparam int CntW = vdi_pkg::CntW;

  vdi_pkg::state_e          state_q, state_d;
  logic [vdi_pkg::TolW-1:0] tol_q;
  logic [IdxW-1:0]          step_q, step_d;
  logic [CntW-1:0]          count_q, count_d;
  logic                     decided_q, decided_d;
  vdi_pkg::vertex_t         probe_q;
  vdi_pkg::result_t         res_q, res_d;
  vdi_pkg::result_t         out_res_q;
  logic                     out_valid_q, out_valid_d;

  vdi_pkg::vertex_t         ring_w [MaxV];
  vdi_pkg::vertex_t         tail_w;
  logic                     shift_w;
  logic                     near_w;
  logic                     in_fire_w;
  logic                     below_cnt_w, at_cnt_w, last_w;
  logic                     hit_now_w, append_now_w, full_now_w;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= vdi_pkg::TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Ring of cells; the head entry wraps to the tail unless a new vertex is appended.
  assign shift_w = (state_q == vdi_pkg::ST_SCAN);
  assign tail_w  = append_now_w ? probe_q : ring_w[0];

  for (genvar k = 0; k < MaxV; k++) begin : g_ring
    if (k == MaxV - 1) begin : g_tail
      vdi_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_w),
        .vtx_i   (tail_w),
        .vtx_o   (ring_w[k])
      );
    end else begin : g_body
      vdi_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_w),
        .vtx_i   (ring_w[k+1]),
        .vtx_o   (ring_w[k])
      );
    end
  end

  // Compare of the probe against the entry now at the head.
  vdi_near u_near (
    .probe_i (probe_q),
    .entry_i (ring_w[0]),
    .tol_i   (tol_q),
    .near_o  (near_w)
  );

  // Scan decisions for the current head entry.
  always_comb begin
    in_fire_w    = in_valid_i && in_ready_o;
    below_cnt_w  = {1'b0, step_q} < count_q;
    at_cnt_w     = {1'b0, step_q} == count_q;
    last_w       = step_q == IdxW'(MaxV - 1);
    hit_now_w    = shift_w && !decided_q && below_cnt_w && near_w;
    append_now_w = shift_w && !decided_q && at_cnt_w;
    full_now_w   = shift_w && !decided_q && last_w && !hit_now_w && !append_now_w;
  end

  // Sequencer and result bookkeeping.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    decided_d   = decided_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      vdi_pkg::ST_IDLE: begin
        if (in_fire_w) begin
          state_d   = vdi_pkg::ST_SCAN;
          step_d    = '0;
          decided_d = 1'b0;
          if (start_mesh_i) begin
            count_d = '0;
          end
        end
      end
      vdi_pkg::ST_SCAN: begin
        step_d = step_q + IdxW'(1);
        if (hit_now_w) begin
          decided_d    = 1'b1;
          res_d.index  = vdi_pkg::OutIdxW'(step_q);
          res_d.is_new = 1'b0;
          res_d.full   = 1'b0;
        end else if (append_now_w) begin
          decided_d    = 1'b1;
          count_d      = count_q + CntW'(1);
          res_d.index  = vdi_pkg::OutIdxW'(step_q);
          res_d.is_new = 1'b1;
          res_d.full   = 1'b0;
        end else if (full_now_w) begin
          decided_d    = 1'b1;
          res_d.index  = '0;
          res_d.is_new = 1'b0;
          res_d.full   = 1'b1;
        end
        if (last_w) begin
          state_d = vdi_pkg::ST_DONE;
        end
      end
      vdi_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = vdi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vdi_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdi_pkg::ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      decided_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      decided_q   <= decided_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: probe vertex, pending result and output word.
  always_ff @(posedge clk_i) begin
    if (in_fire_w) begin
      probe_q.x <= pos_x_i;
      probe_q.y <= pos_y_i;
      probe_q.z <= pos_z_i;
    end
    res_q <= res_d;
    if (state_q == vdi_pkg::ST_DONE && (!out_valid_q || out_ready_i)) begin
      out_res_q <= res_q;
    end
  end

  // Port drive.
  assign in_ready_o     = (state_q == vdi_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = out_res_q.index;
  assign is_new_o       = out_res_q.is_new;
  assign table_full_o   = out_res_q.full;

  // Checks on the scan bookkeeping.
  `VDI_ASSERT(a_count_bound, count_q <= CntW'(MaxV))
  `VDI_ASSERT(a_flags_exclusive, !(out_valid_q && out_res_q.is_new && out_res_q.full))
  `VDI_ASSERT_NEXT(a_append_grows, append_now_w, count_q == $past(count_q) + CntW'(1))
  `VDI_ASSERT_NEXT(a_scan_decides, shift_w && last_w, decided_q && state_q == vdi_pkg::ST_DONE)

endmodule

// ===== rtl/vdi_cell.sv =====
// One table cell: holds one stored vertex and hands it to its neighbor on a shift.
module vdi_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  vdi_pkg::vertex_t vtx_i,
  output vdi_pkg::vertex_t vtx_o
);

  vdi_pkg::vertex_t vtx_q;

  // Payload register, loaded from the neighbor while the ring rotates.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      vtx_q <= vtx_i;
    end
  end

  assign vtx_o = vtx_q;

endmodule

// ===== rtl/vdi_near.sv =====
// Per-axis tolerance compare between the probe vertex and the entry at the ring head.
module vdi_near (
  input  vdi_pkg::vertex_t                 probe_i,
  input  vdi_pkg::vertex_t                 entry_i,
  input  logic [vdi_pkg::TolW-1:0]         tol_i,
  output logic                             near_o
);

  localparam int DiffW = vdi_pkg::CoordW + 1;

  logic signed [DiffW-1:0] dx, dy, dz;
  logic        [DiffW-1:0] mx, my, mz;
  logic        [DiffW-1:0] tol_ext;

  // Differences at one extra bit cannot wrap; magnitudes fit unsigned.
  always_comb begin
    dx = {probe_i.x[vdi_pkg::CoordW-1], probe_i.x} - {entry_i.x[vdi_pkg::CoordW-1], entry_i.x};
    dy = {probe_i.y[vdi_pkg::CoordW-1], probe_i.y} - {entry_i.y[vdi_pkg::CoordW-1], entry_i.y};
    dz = {probe_i.z[vdi_pkg::CoordW-1], probe_i.z} - {entry_i.z[vdi_pkg::CoordW-1], entry_i.z};
    mx = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    my = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
    mz = dz[DiffW-1] ? DiffW'(-dz) : DiffW'(dz);
    tol_ext = DiffW'(tol_i);
    near_o = (mx < tol_ext) && (my < tol_ext) && (mz < tol_ext);
  end

endmodule
